>>> rtl/olp_pkg.sv
// Shared constants, codes and types of the one-pole low-pass filter.
`default_nettype none

package olp_pkg;

    localparam int COEF_FRAC_BITS = 24;

    localparam int SAMPLE_W = 32;
    localparam int GAIN_W   = 32;
    localparam int NORM_W   = 25;
    localparam int FMT_W    = 2;
    localparam int ACC_W    = 64;
    localparam int MUL_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_NORM     = 2'd2;

    // Sample formats.
    localparam logic [FMT_W-1:0] FMT_S8  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_U8  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_S16 = 2'd2;
    localparam logic [FMT_W-1:0] FMT_S32 = 2'd3;

    localparam logic [FMT_W-1:0]  FMT_RESET  = FMT_S8;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd16777216;
    localparam logic [NORM_W-1:0] NORM_RESET = 25'd8388608;

    localparam logic [SAMPLE_W-1:0] U8_OFFSET = 32'd128;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;

    // Operands of the shared saturating adder: result is a + b or a - b.
    typedef struct packed {
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W:0]   b;
        logic                    sub;
    } add_req_t;

endpackage

`default_nettype wire

>>> rtl/olp_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
`default_nettype none

module olp_mul (
    input  wire logic                            aclk,
    input  wire logic [olp_pkg::MUL_W-1:0]       op_a,
    input  wire logic [olp_pkg::MUL_W-1:0]       op_b,
    output logic      [2*olp_pkg::MUL_W-1:0]     prod_reg
);
    import olp_pkg::*;

    logic [2*MUL_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

>>> rtl/olp_add.sv
// Shared 64-bit adder and subtractor with saturated and raw results.
`default_nettype none

module olp_add (
    input  wire olp_pkg::add_req_t                req,
    output logic signed [olp_pkg::ACC_W-1:0]      sum_sat,
    output logic        [olp_pkg::ACC_W-1:0]      sum_raw
);
    import olp_pkg::*;

    logic signed [ACC_W+1:0] a_ext;
    logic signed [ACC_W+1:0] b_ext;
    logic signed [ACC_W+1:0] sum;

    assign a_ext = {{2{req.a[ACC_W-1]}}, req.a};
    assign b_ext = {req.b[ACC_W], req.b};
    assign sum   = req.sub ? (a_ext - b_ext) : (a_ext + b_ext);

    // The raw low word serves magnitudes, where the most negative value maps to 2^63.
    assign sum_raw = sum[ACC_W-1:0];

    always_comb begin
        if (sum[ACC_W+1:ACC_W-1] == 3'b000 || sum[ACC_W+1:ACC_W-1] == 3'b111) begin
            sum_sat = sum[ACC_W-1:0];
        end else if (sum[ACC_W+1]) begin
            sum_sat = ACC_MIN;
        end else begin
            sum_sat = ACC_MAX;
        end
    end

endmodule

`default_nettype wire

>>> rtl/one_pole_lowpass_saturating.sv
// Top level: configuration registers, sequencer and datapath of the one-pole low-pass filter.
// A sample with nonzero gain passes the states GX, ACC, MAG1, MLO1, MHI1, CMB1, Y, D, MAG2,
// MLO2, MHI2, CMB2, INT and DONE before it shows on m_valid, as its five products share one
// 32x32 multiplier and its eight sums share one 64-bit adder. A new sample is taken only in
// idle; with zero gain it skips to DONE. A result waiting on m_ready holds the sequencer.
// Synchronous active-low reset restores the register defaults and clears the integrator.
`default_nettype none

module one_pole_lowpass_saturating (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [olp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [olp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [olp_pkg::SAMPLE_W-1:0]  s_sample_in,
    input  wire logic                                 s_block_start,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [olp_pkg::SAMPLE_W-1:0]       m_sample_out
);
    import olp_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
    localparam logic [ST_W-1:0] ST_GX   = 4'd1;
    localparam logic [ST_W-1:0] ST_ACC  = 4'd2;
    localparam logic [ST_W-1:0] ST_MAG1 = 4'd3;
    localparam logic [ST_W-1:0] ST_MLO1 = 4'd4;
    localparam logic [ST_W-1:0] ST_MHI1 = 4'd5;
    localparam logic [ST_W-1:0] ST_CMB1 = 4'd6;
    localparam logic [ST_W-1:0] ST_Y    = 4'd7;
    localparam logic [ST_W-1:0] ST_D    = 4'd8;
    localparam logic [ST_W-1:0] ST_MAG2 = 4'd9;
    localparam logic [ST_W-1:0] ST_MLO2 = 4'd10;
    localparam logic [ST_W-1:0] ST_MHI2 = 4'd11;
    localparam logic [ST_W-1:0] ST_CMB2 = 4'd12;
    localparam logic [ST_W-1:0] ST_INT  = 4'd13;
    localparam logic [ST_W-1:0] ST_DONE = 4'd14;

    localparam int LO_W  = ACC_W - COEF_FRAC_BITS;
    localparam int INT_W = ACC_W - 1 - COEF_FRAC_BITS;

    logic [ST_W-1:0]            state_reg, state_next;
    logic [FMT_W-1:0]           fmt_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic [NORM_W-1:0]          norm_reg;
    logic signed [ACC_W-1:0]    integ_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [MUL_W-1:0]           xmag_reg;
    logic                       xneg_reg;
    logic signed [ACC_W-1:0]    t_reg;
    logic signed [ACC_W-1:0]    y_reg;
    logic [ACC_W-1:0]           mag_reg;
    logic                       sgn_reg;
    logic [LO_W-1:0]            lo_reg;
    logic [SAMPLE_W-1:0]        res_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_data_reg;

    logic signed [SAMPLE_W-1:0] x_dec;
    logic signed [ACC_W-1:0]    xs;
    logic [MUL_W-1:0]           mul_a, mul_b;
    logic [2*MUL_W-1:0]         prod;
    logic [ACC_W-1:0]           hi_sh;
    logic                       hi_ovf;
    add_req_t                   add_req;
    logic signed [ACC_W-1:0]    add_sat;
    logic [ACC_W-1:0]           add_raw;
    logic [INT_W-1:0]           y_int;
    logic [SAMPLE_W-1:0]        pos_lim, neg_lim;
    logic [SAMPLE_W-1:0]        clamp_res, out_res;
    logic                       accept, out_free;

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_data_reg;

    always_comb begin
        unique case (fmt_reg)
            FMT_S8:  x_dec = {{24{s_sample_in[7]}}, s_sample_in[7:0]};
            FMT_U8:  x_dec = $signed({24'd0, s_sample_in[7:0]}) - $signed(U8_OFFSET);
            FMT_S16: x_dec = {{16{s_sample_in[15]}}, s_sample_in[15:0]};
            FMT_S32: x_dec = s_sample_in;
        endcase
    end

    assign xs = {{(ACC_W-SAMPLE_W-COEF_FRAC_BITS){x_reg[SAMPLE_W-1]}}, x_reg,
                 {COEF_FRAC_BITS{1'b0}}};

    always_comb begin
        unique case (state_reg)
            ST_GX: begin
                mul_a = xmag_reg;
                mul_b = gain_reg;
            end
            ST_MLO1: begin
                mul_a = mag_reg[MUL_W-1:0];
                mul_b = MUL_W'(norm_reg);
            end
            ST_MHI1: begin
                mul_a = mag_reg[ACC_W-1:MUL_W];
                mul_b = MUL_W'(norm_reg);
            end
            ST_MLO2: begin
                mul_a = mag_reg[MUL_W-1:0];
                mul_b = gain_reg;
            end
            ST_MHI2: begin
                mul_a = mag_reg[ACC_W-1:MUL_W];
                mul_b = gain_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    olp_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod)
    );

    // High partial product placed above the low one; too large a high part saturates.
    assign hi_sh  = prod << (MUL_W - COEF_FRAC_BITS);
    assign hi_ovf = (prod[2*MUL_W-1:MUL_W-1+COEF_FRAC_BITS] != '0);

    always_comb begin
        add_req = '0;
        unique case (state_reg)
            ST_ACC: begin
                add_req.a   = integ_reg;
                add_req.b   = {1'b0, prod};
                add_req.sub = xneg_reg;
            end
            ST_MAG1, ST_MAG2: begin
                add_req.b   = {t_reg[ACC_W-1], t_reg};
                add_req.sub = t_reg[ACC_W-1];
            end
            ST_CMB1, ST_CMB2: begin
                add_req.a   = $signed(hi_sh);
                add_req.b   = {{(ACC_W+1-LO_W){1'b0}}, lo_reg};
            end
            ST_Y: begin
                add_req.b   = {t_reg[ACC_W-1], t_reg};
                add_req.sub = sgn_reg;
            end
            ST_D: begin
                add_req.a   = xs;
                add_req.b   = {y_reg[ACC_W-1], y_reg};
                add_req.sub = 1'b1;
            end
            ST_INT: begin
                add_req.a   = y_reg;
                add_req.b   = {t_reg[ACC_W-1], t_reg};
                add_req.sub = sgn_reg;
            end
            default: begin
                add_req = '0;
            end
        endcase
    end

    olp_add u_add (
        .req     (add_req),
        .sum_sat (add_sat),
        .sum_raw (add_raw)
    );

    // Output sample: integer part of the magnitude, clamped, then signed and offset.
    always_comb begin
        unique case (fmt_reg)
            FMT_S8, FMT_U8: begin
                pos_lim = 32'd127;
                neg_lim = 32'd128;
            end
            FMT_S16: begin
                pos_lim = 32'd32767;
                neg_lim = 32'd32768;
            end
            FMT_S32: begin
                pos_lim = 32'h7FFF_FFFF;
                neg_lim = 32'h8000_0000;
            end
        endcase
    end

    assign y_int = t_reg[ACC_W-2:COEF_FRAC_BITS];

    always_comb begin
        if (sgn_reg) begin
            if (y_int > INT_W'(neg_lim)) begin
                clamp_res = '0 - neg_lim;
            end else begin
                clamp_res = '0 - y_int[SAMPLE_W-1:0];
            end
        end else begin
            if (y_int > INT_W'(pos_lim)) begin
                clamp_res = pos_lim;
            end else begin
                clamp_res = y_int[SAMPLE_W-1:0];
            end
        end
        out_res = (fmt_reg == FMT_U8) ? (clamp_res + U8_OFFSET) : clamp_res;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (gain_reg == '0) ? ST_DONE : ST_GX;
                end
            end
            ST_GX:   state_next = ST_ACC;
            ST_ACC:  state_next = ST_MAG1;
            ST_MAG1: state_next = ST_MLO1;
            ST_MLO1: state_next = ST_MHI1;
            ST_MHI1: state_next = ST_CMB1;
            ST_CMB1: state_next = ST_Y;
            ST_Y:    state_next = ST_D;
            ST_D:    state_next = ST_MAG2;
            ST_MAG2: state_next = ST_MLO2;
            ST_MLO2: state_next = ST_MHI2;
            ST_MHI2: state_next = ST_CMB2;
            ST_CMB2: state_next = ST_INT;
            ST_INT:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fmt_reg     <= FMT_RESET;
            gain_reg    <= GAIN_RESET;
            norm_reg    <= NORM_RESET;
            integ_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_SAMPLE_FORMAT: fmt_reg  <= cfg_data[FMT_W-1:0];
                    CFG_COEF_GAIN:     gain_reg <= cfg_data[GAIN_W-1:0];
                    CFG_COEF_NORM:     norm_reg <= cfg_data[NORM_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        x_reg    <= x_dec;
                        xneg_reg <= x_dec[SAMPLE_W-1];
                        xmag_reg <= x_dec[SAMPLE_W-1] ? ('0 - x_dec) : x_dec;
                        // With zero gain the sample passes through; an unsigned one
                        // returns as its raw byte.
                        res_reg  <= (fmt_reg == FMT_U8) ? {24'd0, s_sample_in[7:0]} : x_dec;
                        if (s_block_start) begin
                            integ_reg <= '0;
                        end
                    end
                end
                ST_ACC, ST_D: begin
                    t_reg <= add_sat;
                end
                ST_MAG1, ST_MAG2: begin
                    mag_reg <= add_raw;
                    sgn_reg <= t_reg[ACC_W-1];
                end
                ST_MHI1, ST_MHI2: begin
                    lo_reg <= prod[2*MUL_W-1:COEF_FRAC_BITS];
                end
                ST_CMB1, ST_CMB2: begin
                    t_reg <= hi_ovf ? ACC_MAX : add_sat;
                end
                ST_Y: begin
                    y_reg   <= add_sat;
                    res_reg <= out_res;
                end
                ST_INT: begin
                    integ_reg <= add_sat;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_data_reg <= res_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire
